>>> src/kyts_pkg.sv
// ----------------------------------------------------------------------------
// kyts_pkg
// Shared types and constants of the Knuth-Yao tree sampler.
// ----------------------------------------------------------------------------
package kyts_pkg;

    // Tree geometry: one row per node, one column per stored level.
    localparam int NODE_W   = 7;
    localparam int COL_W    = 6;
    localparam int ADDR_W   = NODE_W + COL_W;
    localparam int ENTRY_W  = 9;
    localparam int LEVEL_W  = 7;
    localparam int SAMPLE_W = 32;

    // Deepest level of a walk: a walk that passes this level without a hit
    // restarts, so no walk goes beyond 64 levels.
    localparam logic [LEVEL_W-1:0] LAST_DEPTH = LEVEL_W'(63);

    // Entry code for an internal node.
    localparam logic [ENTRY_W-1:0] ENTRY_INTERNAL = {ENTRY_W{1'b1}};

    // Item operation codes.
    localparam logic OP_WRITE = 1'b0;
    localparam logic OP_BIT   = 1'b1;

    // Configuration register indexes.
    localparam logic [1:0] REG_FIRST_LEVEL   = 2'd0;
    localparam logic [1:0] REG_LAST_LEVEL    = 2'd1;
    localparam logic [1:0] REG_OUTCOME_COUNT = 2'd2;
    localparam logic [1:0] REG_RESULT_OFFSET = 2'd3;

    typedef struct packed {
        logic [5:0]  first_level;
        logic [6:0]  last_level;
        logic [8:0]  outcome_count;
        logic [31:0] result_offset;
    } t_cfg;

    typedef struct packed {
        logic               we;
        logic [ADDR_W-1:0]  waddr;
        logic [ENTRY_W-1:0] wdata;
        logic               re;
        logic [ADDR_W-1:0]  raddr;
    } t_ram_req;

endpackage

>>> src/kyts_tree_ram.sv
// ----------------------------------------------------------------------------
// kyts_tree_ram
// Simple dual-port RAM, one write and one registered read per cycle.
// ----------------------------------------------------------------------------
module kyts_tree_ram #(
    parameter int ADDR_W = 13,
    parameter int DATA_W = 9
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [ADDR_W-1:0] i_waddr,
    input  logic [DATA_W-1:0] i_wdata,
    input  logic              i_re,
    input  logic [ADDR_W-1:0] i_raddr,
    output logic [DATA_W-1:0] o_rdata
);

    logic [DATA_W-1:0] r_mem [0:(1 << ADDR_W)-1];
    logic [DATA_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // The read data holds while no read is issued.
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

>>> src/kyts_cfg_regs.sv
// ----------------------------------------------------------------------------
// kyts_cfg_regs
// APB register bank holding the sampler configuration.
// ----------------------------------------------------------------------------
module kyts_cfg_regs (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 psel,
    input  logic                 penable,
    input  logic                 pwrite,
    input  logic [3:0]           paddr,
    input  logic [31:0]          pwdata,
    output logic [31:0]          prdata,
    output logic                 pready,
    output kyts_pkg::t_cfg       o_cfg
);

    kyts_pkg::t_cfg r_cfg;
    logic [1:0]     reg_idx;
    logic           wr_en;

    assign reg_idx = paddr[3:2];
    assign wr_en   = psel && penable && pwrite;
    assign pready  = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.first_level   <= 6'd0;
            r_cfg.last_level    <= 7'd64;
            r_cfg.outcome_count <= 9'd256;
            r_cfg.result_offset <= 32'd0;
        end else if (wr_en) begin
            unique case (reg_idx)
                kyts_pkg::REG_FIRST_LEVEL:   r_cfg.first_level   <= pwdata[5:0];
                kyts_pkg::REG_LAST_LEVEL:    r_cfg.last_level    <= pwdata[6:0];
                kyts_pkg::REG_OUTCOME_COUNT: r_cfg.outcome_count <= pwdata[8:0];
                kyts_pkg::REG_RESULT_OFFSET: r_cfg.result_offset <= pwdata;
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (reg_idx)
            kyts_pkg::REG_FIRST_LEVEL:   prdata = {26'd0, r_cfg.first_level};
            kyts_pkg::REG_LAST_LEVEL:    prdata = {25'd0, r_cfg.last_level};
            kyts_pkg::REG_OUTCOME_COUNT: prdata = {23'd0, r_cfg.outcome_count};
            kyts_pkg::REG_RESULT_OFFSET: prdata = r_cfg.result_offset;
            default:                     prdata = 32'd0;
        endcase
    end

    assign o_cfg = r_cfg;

endmodule

>>> src/kyts_walk.sv
// ----------------------------------------------------------------------------
// kyts_walk
// Tree walk control: issues the table access for each item, resolves the
// entry after the table read and holds the result in the output register.
// ----------------------------------------------------------------------------
module kyts_walk (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  kyts_pkg::t_cfg                   i_cfg,
    input  logic                             i_valid,
    output logic                             o_ready,
    input  logic                             i_op,
    input  logic [kyts_pkg::NODE_W-1:0]      i_node,
    input  logic [kyts_pkg::COL_W-1:0]       i_level,
    input  logic [kyts_pkg::ENTRY_W-1:0]     i_entry,
    input  logic                             i_bit_req,
    output kyts_pkg::t_ram_req               o_ram_req,
    input  logic [kyts_pkg::ENTRY_W-1:0]     i_rdata,
    output logic                             o_valid,
    input  logic                             i_ready,
    output logic [kyts_pkg::SAMPLE_W-1:0]    o_sample
);

    // Walk state.
    logic [kyts_pkg::NODE_W-1:0]   r_node, n_node;
    logic [kyts_pkg::LEVEL_W-1:0]  r_level, n_level;

    // Resolve stage, waiting on the table read.
    logic                          r_s1_valid;
    logic [kyts_pkg::NODE_W-1:0]   r_s1_nn;
    logic                          r_s1_outside;
    logic                          r_s1_active;
    logic                          r_s1_past;

    // Output register.
    logic                          r_out_valid;
    logic [kyts_pkg::SAMPLE_W-1:0] r_sample;

    logic                          accept;
    logic                          bit_acc;
    logic [kyts_pkg::NODE_W-1:0]   nn;
    logic [kyts_pkg::COL_W-1:0]    col;
    logic                          active;
    logic                          past;
    logic                          is_outcome;
    logic                          is_internal;
    logic                          below_err;
    logic                          hit;
    logic                          go_on;
    logic                          s1_done;

    assign o_ready = !r_s1_valid;
    assign accept  = i_valid && o_ready;
    assign bit_acc = accept && (i_op == kyts_pkg::OP_BIT);

    // The top bit of the current node shifts out on doubling: then the
    // child lies outside the table.
    assign nn     = {r_node[kyts_pkg::NODE_W-2:0], i_bit_req};
    assign active = r_level >= {1'b0, i_cfg.first_level};
    assign col    = r_level[kyts_pkg::COL_W-1:0] - i_cfg.first_level;
    assign past   = r_level >= i_cfg.last_level;

    always_comb begin
        o_ram_req.we    = accept && (i_op == kyts_pkg::OP_WRITE);
        o_ram_req.waddr = {i_node, i_level};
        o_ram_req.wdata = i_entry;
        o_ram_req.re    = bit_acc;
        o_ram_req.raddr = {nn, col};
    end

    assign is_outcome  = !i_rdata[kyts_pkg::ENTRY_W-1];
    assign is_internal = i_rdata == kyts_pkg::ENTRY_INTERNAL;
    assign below_err   = ({1'b0, i_rdata[kyts_pkg::ENTRY_W-2:0]} + 9'd1)
                         < i_cfg.outcome_count;

    assign hit   = !r_s1_outside && r_s1_active && !r_s1_past
                   && is_outcome && below_err;
    assign go_on = !r_s1_outside && (!r_s1_active || (!r_s1_past && is_internal))
                   && (r_level != kyts_pkg::LAST_DEPTH);

    // A hit can only leave the stage once the output register has room.
    assign s1_done = r_s1_valid && (!hit || !r_out_valid || i_ready);

    always_comb begin
        n_node  = r_node;
        n_level = r_level;
        if (s1_done) begin
            if (go_on) begin
                n_node  = r_s1_nn;
                n_level = r_level + kyts_pkg::LEVEL_W'(1);
            end else begin
                n_node  = '0;
                n_level = '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_node      <= '0;
            r_level     <= '0;
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_node  <= n_node;
            r_level <= n_level;
            if (bit_acc) begin
                r_s1_valid <= 1'b1;
            end else if (s1_done) begin
                r_s1_valid <= 1'b0;
            end
            if (s1_done && hit) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (bit_acc) begin
            r_s1_nn      <= nn;
            r_s1_outside <= r_node[kyts_pkg::NODE_W-1];
            r_s1_active  <= active;
            r_s1_past    <= past;
        end
        if (s1_done && hit) begin
            r_sample <= {24'd0, i_rdata[kyts_pkg::ENTRY_W-2:0]} + i_cfg.result_offset;
        end
    end

    assign o_valid  = r_out_valid;
    assign o_sample = r_sample;

`ifndef SYNTHESIS
    a_hit_restarts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s1_done && hit) |=> (r_level == '0 && r_node == '0))
        else $error("walk did not restart after a hit");

    a_root_at_level_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_level == '0) |-> (r_node == '0))
        else $error("non-root node at level zero");

    a_depth_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_level <= kyts_pkg::LAST_DEPTH)
        else $error("walk depth beyond limit");

    a_bit_enters_stage: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        bit_acc |=> (r_s1_valid && $stable(r_level)))
        else $error("random bit item lost before resolution");
`endif

endmodule

>>> src/knuth_yao_tree_sampler.sv
// ----------------------------------------------------------------------------
// knuth_yao_tree_sampler
// Knuth-Yao discrete Gaussian sampler walking a stored generating tree.
// ----------------------------------------------------------------------------
// Usage: software loads the tree through the input channel with write items
// (i_op = 0: entry at row i_node, column i_level), then streams random bit
// items (i_op = 1). Each bit moves the walk one level down; a terminal
// outcome below the error bucket emits one item on the output channel equal
// to outcome plus result_offset. Dead ends restart the walk with no output.
// Configuration is written over the APB port; the user must do so only while
// the block is idle, which the block does not enforce. A write item is taken
// whenever the input is ready; a bit item holds the input off until its
// registered table read is resolved, as its entry decides the next node
// before the following bit may enter. A sample is presented on the output
// channel from the output register, which frees the input side, so a new
// item is taken while a sample waits; a hit that finds the output register
// still full holds the resolve stage until the receiver takes the waiting
// sample. Reset restores the register defaults and the walk to the root;
// the tree memory is not cleared and must be loaded before use.
// ----------------------------------------------------------------------------
module knuth_yao_tree_sampler (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [3:0]                    paddr,
    input  logic [31:0]                   pwdata,
    output logic [31:0]                   prdata,
    output logic                          pready,
    input  logic                          i_valid,
    output logic                          o_ready,
    input  logic                          i_op,
    input  logic [kyts_pkg::NODE_W-1:0]   i_node,
    input  logic [kyts_pkg::COL_W-1:0]    i_level,
    input  logic signed [kyts_pkg::ENTRY_W-1:0] i_entry,
    input  logic                          i_bit_req,
    output logic                          o_valid,
    input  logic                          i_ready,
    output logic signed [kyts_pkg::SAMPLE_W-1:0] o_sample
);

    kyts_pkg::t_cfg                 cfg;
    kyts_pkg::t_ram_req             ram_req;
    logic [kyts_pkg::ENTRY_W-1:0]   rdata;
    logic [kyts_pkg::SAMPLE_W-1:0]  sample;

    kyts_cfg_regs u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    kyts_tree_ram #(
        .ADDR_W (kyts_pkg::ADDR_W),
        .DATA_W (kyts_pkg::ENTRY_W)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_req.we),
        .i_waddr (ram_req.waddr),
        .i_wdata (ram_req.wdata),
        .i_re    (ram_req.re),
        .i_raddr (ram_req.raddr),
        .o_rdata (rdata)
    );

    kyts_walk u_walk (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cfg     (cfg),
        .i_valid   (i_valid),
        .o_ready   (o_ready),
        .i_op      (i_op),
        .i_node    (i_node),
        .i_level   (i_level),
        .i_entry   (i_entry),
        .i_bit_req (i_bit_req),
        .o_ram_req (ram_req),
        .i_rdata   (rdata),
        .o_valid   (o_valid),
        .i_ready   (i_ready),
        .o_sample  (sample)
    );

    assign o_sample = $signed(sample);

endmodule
